// ----- hdl/ordered_list_positional_edit_defines.svh -----
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shared assertion shorthands for the positional edit list block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_POSITIONAL_EDIT_DEFINES_SVH
`define ORDERED_LIST_POSITIONAL_EDIT_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define OLPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define OLPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/olpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered list package
// Sizes, codes and the cell command type of the positional edit list.
// ----------------------------------------------------------------------------
package olpe_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int FUNC_W     = 3;
  localparam int POS_W      = 7;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;
  // Positions and counts are compared at this common width.
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int GRP_SIZE   = 8;
  localparam int NUM_GRP    = (LIST_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  localparam int S_FIELDS_W = FUNC_W + POS_W + DATA_W;
  localparam int M_FIELDS_W = STATUS_W + 2 * DATA_W + POS_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_AT    = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_BACK  = 3'd4,
    FN_DEL_AT    = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RED  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
  } cell_cmd_t;

endpackage

// ----- hdl/ordered_list_positional_edit.sv -----
// After the request transfer the block passes S_RED and S_FIN and offers the
// result transfer in S_OUT; no new request is taken until that result is taken.
// These states serve the two-stage OR tree that finds the tail cell's element
// and the single output register; all cells shift together in the accept cycle.
// Reset empties the list at once (count zero); cell contents are not cleared.
// ----------------------------------------------------------------------------
// Ordered list with positional edit
// A chain of element cells with insert and delete at front, back or position.
// ----------------------------------------------------------------------------
`include "ordered_list_positional_edit_defines.svh"

module ordered_list_positional_edit
  import olpe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // func [2:0], position [9:3], value [41:10], zero padding above
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status [1:0], front_value [33:2], back_value [65:34],
  // element_count [72:66], zero padding above
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  status_e                     status_q, status_d;
  logic [M_TDATA_W-1:0]        tdata_q;

  logic                        s_acc;
  logic [FUNC_W-1:0]           func;
  logic [POS_W-1:0]            pos_in;
  logic [DATA_W-1:0]           value_in;
  logic [CMP_W-1:0]            pos_c, cnt_c;
  logic                        full, empty;
  cell_cmd_t                   cmd, cmd_act;

  logic [LIST_DEPTH-1:0][DATA_W-1:0] cell_data;
  logic [LIST_DEPTH-1:0][DATA_W-1:0] cell_taps;
  logic [DATA_W-1:0]           back_val, front_val;
  logic [CMP_W-1:0]            count_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign func     = s_axis_tdata[FUNC_W-1:0];
  assign pos_in   = s_axis_tdata[FUNC_W +: POS_W];
  assign value_in = s_axis_tdata[FUNC_W+POS_W +: DATA_W];

  assign pos_c = CMP_W'(pos_in);
  assign cnt_c = CMP_W'(count_q);
  assign full  = (count_q == CNT_W'(LIST_DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    cmd      = '0;
    status_d = ST_DONE;
    unique case (func)
      FN_INS_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cmd.pos = '0;
        end
      end
      FN_INS_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cmd.pos = cnt_c;
        end
      end
      FN_INS_AT: begin
        if (pos_c > cnt_c) begin
          status_d = ST_BADPOS;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cmd.pos = pos_c;
        end
      end
      FN_DEL_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.del = 1'b1;
          cmd.pos = '0;
        end
      end
      FN_DEL_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.del = 1'b1;
          cmd.pos = cnt_c - CMP_W'(1);
        end
      end
      FN_DEL_AT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status_d = ST_BADPOS;
        end else begin
          cmd.del = 1'b1;
          cmd.pos = pos_c;
        end
      end
      default: begin
        // Unused function codes leave the list untouched.
        status_d = ST_DONE;
      end
    endcase
  end

  always_comb begin
    cmd_act     = cmd;
    cmd_act.ins = cmd.ins && s_acc;
    cmd_act.del = cmd.del && s_acc;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_act.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_act.del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_val, right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = cell_data[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_data[i+1];
    end

    olpe_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_act),
      .value_i (value_in),
      .idx_i   (CMP_W'(i)),
      .count_i (count_q),
      .left_i  (left_val),
      .right_i (right_val),
      .data_o  (cell_data[i]),
      .tap_o   (cell_taps[i])
    );
  end

  olpe_reduce u_reduce (
    .clk_i  (clk_i),
    .load_i (state_q == S_RED),
    .taps_i (cell_taps),
    .back_o (back_val)
  );

  assign front_val = empty ? '0 : cell_data[0];
  assign count_ext = CMP_W'(count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          state_d = S_RED;
        end
      end
      S_RED:  state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= ST_DONE;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (s_acc) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN) begin
      tdata_q <= M_TDATA_W'({count_ext[POS_W-1:0], back_val, front_val, status_q});
    end
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = tdata_q;

  `OLPE_ASSERT(a_count_bound, count_q <= CNT_W'(LIST_DEPTH), "element count above list depth")
  `OLPE_ASSERT_NEXT(a_accept_to_reduce, s_acc, state_q == S_RED, "accepted request did not start")
  `OLPE_ASSERT_NEXT(a_insert_grows, cmd_act.ins, count_q == $past(count_q) + CNT_W'(1), "insert did not grow the list")
  `OLPE_ASSERT_NEXT(a_delete_shrinks, cmd_act.del, count_q == $past(count_q) - CNT_W'(1), "delete did not shrink the list")
  `OLPE_ASSERT(a_one_at_a_time, m_axis_tvalid |-> !s_axis_tready, "request taken while a result is pending")

endmodule

// ----- hdl/olpe_cell.sv -----
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one element and shifts with its neighbours on insert and delete.
// ----------------------------------------------------------------------------
module olpe_cell
  import olpe_pkg::*;
(
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [CMP_W-1:0]  idx_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] tap_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic              tail;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i > cmd_i.pos) begin
        data_d = left_i;
      end else if (idx_i == cmd_i.pos) begin
        data_d = value_i;
      end
    end else if (cmd_i.del) begin
      if (idx_i >= cmd_i.pos) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // The cell holding the last element presents it to the back value tree.
  assign tail   = (CMP_W'(count_i) == idx_i + CMP_W'(1));
  assign data_o = data_q;
  assign tap_o  = tail ? data_q : '0;

endmodule

// ----- hdl/olpe_reduce.sv -----
// ----------------------------------------------------------------------------
// Ordered list back value tree
// Two-level registered OR tree that picks the tail cell's element.
// ----------------------------------------------------------------------------
module olpe_reduce
  import olpe_pkg::*;
(
  input  logic                               clk_i,
  input  logic                               load_i,
  input  logic [LIST_DEPTH-1:0][DATA_W-1:0]  taps_i,
  output logic [DATA_W-1:0]                  back_o
);

  logic [NUM_GRP-1:0][DATA_W-1:0] part_q, part_d;

  always_comb begin
    part_d = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < LIST_DEPTH) begin
          part_d[g] = part_d[g] | taps_i[g * GRP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      part_q <= part_d;
    end
  end

  always_comb begin
    back_o = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      back_o = back_o | part_q[g];
    end
  end

endmodule

// ----- verif/tb_ordered_list_positional_edit.sv -----
// ----------------------------------------------------------------------------
// Ordered list positional edit testbench
// Drives insert and delete requests into the list block over its request
// stream, mirrors the list contents in a scoreboard and checks the status,
// front, back and count of every result transfer against the mirror.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ordered_list_positional_edit;
  import olpe_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam int SIDE_REQ     = 0;
  localparam int SIDE_RES     = 1;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 12;

  // Function codes that the block treats as no operation.
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } edit_req_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] back;
    logic [CNT_W-1:0]  count;
  } list_view_t;

  class list_mirror;
    logic [DATA_W-1:0] cells [LIST_DEPTH];
    int                held;
    list_view_t        awaited [$];
    int unsigned       failures;
    int unsigned       checked;
    int unsigned       peak;
    int unsigned       status_seen [4];

    function new();
      held     = 0;
      failures = 0;
      checked  = 0;
      peak     = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function status_e insert_at(int at, logic [DATA_W-1:0] v);
      if (held >= LIST_DEPTH) return ST_FULL;
      for (int i = held; i > at; i--) cells[i] = cells[i-1];
      cells[at] = v;
      held++;
      return ST_DONE;
    endfunction

    function status_e delete_at(int at);
      if (held == 0) return ST_EMPTY;
      if (at >= held) return ST_BADPOS;
      for (int i = at; i + 1 < held; i++) cells[i] = cells[i+1];
      held--;
      return ST_DONE;
    endfunction

    // Applies an accepted request to the mirror and queues the view it yields.
    function void record_request(edit_req_t req);
      list_view_t view;
      status_e    st;
      st = ST_DONE;
      case (req.func)
        FN_INS_FRONT: st = insert_at(0, req.value);
        FN_INS_BACK:  st = insert_at(held, req.value);
        FN_INS_AT: begin
          // The range check takes priority over the full check.
          if (int'(req.position) > held) st = ST_BADPOS;
          else st = insert_at(int'(req.position), req.value);
        end
        FN_DEL_FRONT: st = delete_at(0);
        FN_DEL_BACK: begin
          if (held == 0) st = ST_EMPTY;
          else st = delete_at(held - 1);
        end
        FN_DEL_AT:    st = delete_at(int'(req.position));
        default:      st = ST_DONE;
      endcase
      view.status = st;
      view.front  = (held == 0) ? '0 : cells[0];
      view.back   = (held == 0) ? '0 : cells[held-1];
      view.count  = CNT_W'(held);
      awaited.push_back(view);
      status_seen[int'(st)]++;
      if (held > peak) peak = held;
    endfunction

    function void check_view(logic [M_TDATA_W-1:0] data);
      list_view_t got;
      list_view_t want;
      got.status = status_e'(data[STATUS_W-1:0]);
      got.front  = data[STATUS_W +: DATA_W];
      got.back   = data[STATUS_W+DATA_W +: DATA_W];
      got.count  = data[STATUS_W+2*DATA_W +: CNT_W];
      checked++;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("[%0t] unexpected result transfer: status %0d front %0d back %0d count %0d",
                   $realtime, got.status, $signed(got.front), $signed(got.back), got.count);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.front !== want.front ||
          got.back !== want.back || got.count !== want.count) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("[%0t] result %0d differs", $realtime, checked);
          $display("  expected: status %0d front %0d back %0d count %0d",
                   want.status, $signed(want.front), $signed(want.back), want.count);
          $display("  actual:   status %0d front %0d back %0d count %0d",
                   got.status, $signed(got.front), $signed(got.back), got.count);
        end
      end
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        failures += awaited.size();
        $display("%0d expected results never arrived", awaited.size());
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  list_mirror mirror = new();
  int         calm_left [2] = '{0, 0};

  ordered_list_positional_edit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle cycles before the next transfer on one side, with occasional
  // stretches in which that side never idles.
  function automatic int unsigned idle_cycles(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, 9);
  endfunction

  // Offers one request and returns once it has been taken. The valid stays
  // high across back-to-back requests.
  task automatic issue(input logic [FUNC_W-1:0] func, input int pos,
                       input logic [DATA_W-1:0] value);
    edit_req_t            req;
    logic [S_TDATA_W-1:0] word;
    int unsigned          gap;
    req.func     = func;
    req.position = POS_W'(pos);
    req.value    = value;
    word = '0;
    word[FUNC_W-1:0]              = req.func;
    word[FUNC_W +: POS_W]         = req.position;
    word[FUNC_W+POS_W +: DATA_W]  = req.value;
    gap = idle_cycles(SIDE_REQ);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.record_request(req);
  endtask

  initial begin : result_sink
    int unsigned gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = idle_cycles(SIDE_RES);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      mirror.check_view(m_axis_tdata);
    end
  end

  initial begin : stimulus
    int unsigned       roll;
    int unsigned       pick;
    logic [FUNC_W-1:0] fn;
    int                pos;
    int                bound;
    logic [DATA_W-1:0] val;
    bit                filling;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Deletes and bad positions on an empty list.
    issue(FN_DEL_FRONT, 0, 32'h0000_0000);
    issue(FN_DEL_BACK, 0, 32'h0000_0000);
    issue(FN_DEL_AT, 0, 32'h0000_0000);
    issue(FN_INS_AT, 1, 32'h1234_5678);
    issue(FN_INS_AT, 127, 32'h1234_5678);
    // Build up a few elements with extreme values.
    issue(FN_INS_AT, 0, 32'h8000_0000);
    issue(FN_INS_BACK, 0, 32'h7FFF_FFFF);
    issue(FN_INS_FRONT, 0, 32'h0000_0000);
    issue(FN_INS_FRONT, 0, 32'hFFFF_FFFF);
    issue(FN_INS_AT, 2, 32'h0000_0005);
    issue(FN_INS_AT, 5, 32'h5555_5555);
    // Positional delete just past the end and far past it.
    issue(FN_DEL_AT, 6, 32'h0000_0000);
    issue(FN_DEL_AT, 64, 32'h0000_0000);
    issue(FN_DEL_AT, 2, 32'h0000_0000);
    // Spare function codes leave the list untouched.
    issue(FN_SPARE_A, 0, 32'h0000_0000);
    issue(FN_SPARE_B, 127, 32'hFFFF_FFFF);
    issue(FN_DEL_BACK, 0, 32'h0000_0000);
    issue(FN_DEL_FRONT, 0, 32'h0000_0000);
    issue(FN_DEL_AT, 0, 32'h0000_0000);
    issue(FN_DEL_BACK, 0, 32'h0000_0000);
    issue(FN_DEL_AT, 0, 32'h0000_0000);
    issue(FN_DEL_AT, 0, 32'h0000_0000);
    issue(FN_INS_BACK, 0, 32'hAAAA_AAAA);
    issue(FN_DEL_FRONT, 0, 32'h0000_0000);

    // Alternate between filling the list up to full and draining it empty,
    // so that both boundaries are hit repeatedly.
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (filling && mirror.held == LIST_DEPTH && $urandom_range(0, 5) == 0) filling = 1'b0;
      else if (!filling && mirror.held == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) == 0) filling = !filling;

      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 2);
      if (roll < 2) begin
        fn = pick[0] ? FN_SPARE_A : FN_SPARE_B;
      end else if (roll < (filling ? 80 : 20)) begin
        case (pick)
          0:       fn = FN_INS_FRONT;
          1:       fn = FN_INS_BACK;
          default: fn = FN_INS_AT;
        endcase
      end else begin
        case (pick)
          0:       fn = FN_DEL_FRONT;
          1:       fn = FN_DEL_BACK;
          default: fn = FN_DEL_AT;
        endcase
      end

      if (fn == FN_INS_AT || fn == FN_DEL_AT) begin
        bound = (fn == FN_INS_AT) ? mirror.held : mirror.held - 1;
        pick  = $urandom_range(0, 9);
        if (bound < 0) pos = $urandom_range(0, 3);
        else if (pick < 8) pos = $urandom_range(0, bound);
        else if (pick == 8) pos = bound + 1;
        else pos = $urandom_range(0, 127);
      end else begin
        pos = $urandom_range(0, 127);
      end

      case ($urandom_range(0, 7))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        default: val = $urandom();
      endcase
      issue(fn, pos, val);
    end
    s_axis_tvalid <= 1'b0;

    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mirror.close_out();

    $display("Checked %0d results: %0d done, %0d empty, %0d bad position, %0d full.",
             mirror.checked, mirror.status_seen[int'(ST_DONE)],
             mirror.status_seen[int'(ST_EMPTY)], mirror.status_seen[int'(ST_BADPOS)],
             mirror.status_seen[int'(ST_FULL)]);
    $display("Occupancy reached %0d of %0d cells; %0d failures in total.",
             mirror.peak, LIST_DEPTH, mirror.failures);
    if (mirror.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Far beyond the slowest correct run of a few hundred microseconds.
  initial begin
    #2_000_000;
    $display("Run stopped by the watchdog with transfers still outstanding.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/olpe_pkg.sv
hdl/olpe_cell.sv
hdl/olpe_reduce.sv
hdl/ordered_list_positional_edit.sv
verif/tb_ordered_list_positional_edit.sv
